>>> hdl/pwm_tc_pkg.sv
// Shared types, command codes and constants for the PWM timing calculator.
`timescale 1ns / 1ps

package pwm_tc_pkg;

    localparam int FREQ_W = 27;
    localparam int NUM_W = FREQ_W + 1;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int VAL_W = 16;
    localparam int DIVR_W = VAL_W + 1;

    localparam int COUNTER_RANGE = 65536;
    localparam int CNT_SHIFT = $clog2(COUNTER_RANGE);

    // The divider saturates at 65536, so the prescaler tops out at all ones.
    localparam logic [NUM_W-1:0] PSC_MAX = NUM_W'(65535);
    localparam logic [NUM_W-1:0] PER_LIMIT = NUM_W'(65536);

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_FAULT = 2'd2;

    localparam logic CFG_CLOCK_HZ = 1'b0;
    localparam logic CFG_FAULT_FREQ = 1'b1;

    localparam logic [FREQ_W-1:0] CLOCK_HZ_RESET = FREQ_W'(24000000);
    localparam logic [FREQ_W-1:0] FAULT_FREQ_RESET = FREQ_W'(5700);

    typedef struct packed {
        logic [1:0]        cmd;
        logic [FREQ_W-1:0] frequency;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] prescaler_value;
        logic [VAL_W-1:0] period_value;
        logic [VAL_W-1:0] compare_value;
        logic             applied;
        logic             error_flag;
    } out_item_t;

endpackage

>>> hdl/pwm_tc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module pwm_tc_div
    import pwm_tc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [FREQ_W-1:0] denom,
    output logic              busy,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [FREQ_W-1:0] den_reg, den_next;

    logic [NUM_W-1:0]  trial;
    logic [NUM_W-1:0]  diff;
    logic              fits;

    // The numerator shifts out of the top of quo_reg while quotient bits enter below.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff = trial - {1'b0, den_reg};
    assign fits = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = numer;
            den_next = denom;
        end else if (busy_reg) begin
            rem_next = fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> hdl/pwm_timing_calculator.sv
// Top level: command decode, division sequencer, timing state and result register.
// An item that computes new timing runs three serial 28-bit divisions on one shared
// divider; the next item is accepted only once its result has been committed.
// An item that computes nothing (equal request, fault before start, unused command, error)
// skips the divider and goes straight to the done state; a stalled result holds it there.
// aresetn is synchronous, active low: timing, frequency and started clear, and the
// registers return to 24 MHz clock and 5700 Hz fault frequency.
`timescale 1ns / 1ps

module pwm_timing_calculator
    import pwm_tc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [FREQ_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_D1 = 3'd1;
    localparam logic [2:0] ST_D2 = 3'd2;
    localparam logic [2:0] ST_D3 = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [FREQ_W-1:0] clock_hz_reg, fault_freq_reg;
    logic [FREQ_W-1:0] cur_freq_reg;
    logic              started_reg;
    logic [VAL_W-1:0]  cur_psc_reg, cur_per_reg, cur_cmp_reg;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic              mark_reg, mark_next;
    logic              apply_reg, apply_next;
    logic              err_reg, err_next;
    logic [VAL_W-1:0]  psc_reg, psc_next;
    logic [VAL_W-1:0]  per_reg, per_next;
    logic [VAL_W-1:0]  cmp_reg, cmp_next;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              div_start;
    logic [NUM_W-1:0]  div_numer;
    logic [FREQ_W-1:0] div_denom;
    logic              div_busy;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;

    logic              accept;
    logic              out_free;
    logic              commit;
    logic [FREQ_W-1:0] freq_eff;
    logic              do_compute;
    logic              bad_freq;
    logic [NUM_W-1:0]  counts_m1;
    logic [NUM_W-1:0]  div_hi;
    logic [VAL_W-1:0]  psc_calc;
    logic [DIVR_W-1:0] divider_calc;
    logic [NUM_W-1:0]  q_m1;
    logic [VAL_W-1:0]  per_calc;
    logic [DIVR_W-1:0] per_plus1;
    logic [VAL_W-1:0]  cmp_calc;

    function automatic logic [VAL_W-1:0] cmp_of(input logic [VAL_W-1:0] per);
        logic [DIVR_W-1:0] sum;
        sum = {1'b0, per} + DIVR_W'(1);
        return sum[DIVR_W-1:1];
    endfunction

    pwm_tc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit = (state_reg == ST_DONE) && out_free;
    assign cfg_ready = 1'b1;

    // Fault replaces the requested frequency with the configured one.
    assign freq_eff = (s_data.cmd == CMD_FAULT) ? fault_freq_reg : s_data.frequency;
    assign bad_freq = (freq_eff == '0) || (freq_eff > clock_hz_reg);

    always_comb begin
        unique case (s_data.cmd)
            CMD_INIT:  do_compute = 1'b1;
            CMD_SET:   do_compute = (s_data.frequency != cur_freq_reg);
            CMD_FAULT: do_compute = started_reg && (fault_freq_reg != cur_freq_reg);
            default:   do_compute = 1'b0;
        endcase
    end

    // Prescaler from the rounded count: divider = (counts - 1) / range + 1, saturated.
    assign counts_m1 = div_quot - NUM_W'(1);
    assign div_hi = counts_m1 >> CNT_SHIFT;
    assign psc_calc = (div_hi > PSC_MAX) ? VAL_W'(PSC_MAX) : div_hi[VAL_W-1:0];
    assign divider_calc = {1'b0, psc_calc} + DIVR_W'(1);

    // Period from the second rounded quotient, saturated to the counter width.
    assign q_m1 = div_quot - NUM_W'(1);
    always_comb begin
        priority if (div_quot == '0) begin
            per_calc = '0;
        end else if (div_quot > PER_LIMIT) begin
            per_calc = VAL_W'(PSC_MAX);
        end else begin
            per_calc = q_m1[VAL_W-1:0];
        end
    end
    assign per_plus1 = {1'b0, per_calc} + DIVR_W'(1);
    assign cmp_calc = per_plus1[DIVR_W-1:1];

    always_comb begin
        state_next = state_reg;
        freq_next = freq_reg;
        mark_next = mark_reg;
        apply_next = apply_reg;
        err_next = err_reg;
        psc_next = psc_reg;
        per_next = per_reg;
        cmp_next = cmp_reg;
        div_start = 1'b0;
        div_numer = '0;
        div_denom = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    freq_next = freq_eff;
                    mark_next = (s_data.cmd == CMD_INIT);
                    apply_next = 1'b0;
                    err_next = do_compute && bad_freq;
                    if (do_compute && !bad_freq) begin
                        // Rounded count of timer clocks per PWM cycle.
                        div_start = 1'b1;
                        div_numer = {1'b0, clock_hz_reg} + {2'b0, freq_eff[FREQ_W-1:1]};
                        div_denom = freq_eff;
                        state_next = ST_D1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_D1: begin
                if (div_done) begin
                    psc_next = psc_calc;
                    div_start = 1'b1;
                    div_numer = {1'b0, clock_hz_reg};
                    div_denom = FREQ_W'(divider_calc);
                    state_next = ST_D2;
                end
            end
            ST_D2: begin
                if (div_done) begin
                    // Prescaled clock, rounded to the nearest count of the request.
                    div_start = 1'b1;
                    div_numer = div_quot + {2'b0, freq_reg[FREQ_W-1:1]};
                    div_denom = freq_reg;
                    state_next = ST_D3;
                end
            end
            ST_D3: begin
                if (div_done) begin
                    per_next = per_calc;
                    cmp_next = cmp_calc;
                    apply_next = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clock_hz_reg <= CLOCK_HZ_RESET;
            fault_freq_reg <= FAULT_FREQ_RESET;
            cur_freq_reg <= '0;
            started_reg <= 1'b0;
            cur_psc_reg <= '0;
            cur_per_reg <= '0;
            cur_cmp_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_CLOCK_HZ:   clock_hz_reg <= cfg_data;
                    CFG_FAULT_FREQ: fault_freq_reg <= cfg_data;
                    default:        clock_hz_reg <= clock_hz_reg;
                endcase
            end
            if (commit && apply_reg) begin
                cur_freq_reg <= freq_reg;
                cur_psc_reg <= psc_reg;
                cur_per_reg <= per_reg;
                cur_cmp_reg <= cmp_reg;
                if (mark_reg) begin
                    started_reg <= 1'b1;
                end
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        freq_reg <= freq_next;
        mark_reg <= mark_next;
        apply_reg <= apply_next;
        err_reg <= err_next;
        psc_reg <= psc_next;
        per_reg <= per_next;
        cmp_reg <= cmp_next;
        if (commit) begin
            m_data_reg.prescaler_value <= apply_reg ? psc_reg : cur_psc_reg;
            m_data_reg.period_value <= apply_reg ? per_reg : cur_per_reg;
            m_data_reg.compare_value <= apply_reg ? cmp_reg : cur_cmp_reg;
            m_data_reg.applied <= apply_reg;
            m_data_reg.error_flag <= err_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // A result never reports both new timing and an error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.applied && m_data.error_flag))
        else $error("result carries both applied and error");

    // Applied timing always has the half-duty compare of its period.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.applied) |->
            (m_data.compare_value == cmp_of(m_data.period_value)))
        else $error("compare value does not match period");

    // The divider only runs while a division state waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == ST_D1 || state_reg == ST_D2 || state_reg == ST_D3))
        else $error("divider busy outside a division state");

    // An accepted item closes the input until its result is committed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted twice without a result");

endmodule

>>> sim/pwm_tc_monitor.sv
// Channel monitor for the PWM timing calculator: predicts each result and compares it.
`timescale 1ns / 1ps

module pwm_tc_monitor
    import pwm_tc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [FREQ_W-1:0] cfg_data,
    output int                mismatches,
    output int                outstanding
);

    logic [FREQ_W-1:0] clock_hz_q;
    logic [FREQ_W-1:0] fault_hz_q;
    logic [FREQ_W-1:0] cur_freq;
    logic              started_q;
    logic [VAL_W-1:0]  cur_psc;
    logic [VAL_W-1:0]  cur_per;
    logic [VAL_W-1:0]  cur_cmp;
    out_item_t         timing_q[$];

    // Returns 0 when the frequency is zero or above the timer clock.
    function automatic logic fit_timing(input logic [FREQ_W-1:0] freq,
                                        output logic [VAL_W-1:0] psc,
                                        output logic [VAL_W-1:0] per,
                                        output logic [VAL_W-1:0] cmp);
        logic [63:0] clk;
        logic [63:0] fr;
        logic [63:0] counts;
        logic [63:0] divider;
        logic [63:0] q;
        logic [63:0] per64;
        clk = 64'(clock_hz_q);
        fr = 64'(freq);
        psc = '0;
        per = '0;
        cmp = '0;
        if (fr == 0 || fr > clk) begin
            return 1'b0;
        end
        counts = (clk + fr / 2) / fr;
        if (counts == 0) begin
            counts = 1;
        end
        divider = (counts - 1) / 64'(COUNTER_RANGE) + 1;
        if (divider > 64'(COUNTER_RANGE)) begin
            divider = 64'(COUNTER_RANGE);
        end
        q = (clk / divider + fr / 2) / fr;
        per64 = (q == 0) ? 64'd0 : q - 1;
        if (per64 > 64'd65535) begin
            per64 = 64'd65535;
        end
        psc = VAL_W'(divider - 1);
        per = VAL_W'(per64);
        cmp = VAL_W'((per64 + 1) / 2);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic predict_timing(input in_item_t item);
        logic [FREQ_W-1:0] freq;
        logic              compute;
        logic [VAL_W-1:0]  psc;
        logic [VAL_W-1:0]  per;
        logic [VAL_W-1:0]  cmp;
        out_item_t         res;
        freq = item.frequency;
        compute = 1'b0;
        res = '0;
        case (item.cmd)
            CMD_INIT: compute = 1'b1;
            CMD_SET: compute = (freq != cur_freq);
            CMD_FAULT: begin
                if (started_q) begin
                    freq = fault_hz_q;
                    compute = (freq != cur_freq);
                end
            end
            default: compute = 1'b0;
        endcase
        if (compute) begin
            if (fit_timing(freq, psc, per, cmp)) begin
                cur_psc = psc;
                cur_per = per;
                cur_cmp = cmp;
                cur_freq = freq;
                if (item.cmd == CMD_INIT) begin
                    started_q = 1'b1;
                end
                res.applied = 1'b1;
            end else begin
                res.error_flag = 1'b1;
            end
        end
        res.prescaler_value = cur_psc;
        res.period_value = cur_per;
        res.compare_value = cur_cmp;
        timing_q.push_back(res);
    endtask

    task automatic check_timing(input out_item_t got);
        out_item_t want;
        if (timing_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result psc=%0d per=%0d cmp=%0d",
                got.prescaler_value, got.period_value, got.compare_value));
        end else begin
            want = timing_q.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf(
                    "got psc=%0d per=%0d cmp=%0d app=%b err=%b, want %0d %0d %0d %b %b",
                    got.prescaler_value, got.period_value, got.compare_value,
                    got.applied, got.error_flag, want.prescaler_value,
                    want.period_value, want.compare_value, want.applied,
                    want.error_flag));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_q = CLOCK_HZ_RESET;
            fault_hz_q = FAULT_FREQ_RESET;
            cur_freq = '0;
            started_q = 1'b0;
            cur_psc = '0;
            cur_per = '0;
            cur_cmp = '0;
            mismatches = 0;
            timing_q.delete();
        end else begin
            // The result leaving now always belongs to an item accepted earlier.
            if (m_valid && m_ready) begin
                check_timing(m_data);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CLOCK_HZ) begin
                    clock_hz_q = cfg_data;
                end else begin
                    fault_hz_q = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                predict_timing(s_data);
            end
        end
        outstanding = timing_q.size();
    end

endmodule

>>> sim/tb_top.sv
// Testbench top for the PWM timing calculator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import pwm_tc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 118;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [FREQ_W-1:0] cfg_data;
    int                mismatches;
    int                outstanding;

    int                idle_pct;
    int                stall_pct;
    logic [FREQ_W-1:0] clk_hz;
    logic [FREQ_W-1:0] fault_hz;
    logic [FREQ_W-1:0] last_freq;

    pwm_timing_calculator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwm_tc_monitor u_mon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // The result side stalls at random, with a new decision every cycle.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [FREQ_W-1:0] freq);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= {cmd, freq};
        last_freq = freq;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Registers change only once every result has drained.
    task automatic write_register(input logic index, input logic [FREQ_W-1:0] value);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (index == CFG_CLOCK_HZ) begin
            clk_hz = value;
        end else begin
            fault_hz = value;
        end
    endtask

    function automatic logic [FREQ_W-1:0] pick_frequency();
        int unsigned roll;
        logic [31:0] wide;
        roll = $urandom_range(99);
        if (roll < 5) begin
            return '0;
        end else if (roll < 12) begin
            return last_freq;
        end else if (roll < 18) begin
            return fault_hz;
        end else if (roll < 27) begin
            wide = 32'(clk_hz) + $urandom_range(1000, 1);
            return (wide > 32'(FREQ_MAX)) ? FREQ_MAX : FREQ_W'(wide);
        end else if (roll < 37) begin
            return FREQ_W'($urandom_range(200, 1));
        end else if (roll < 45) begin
            wide = (clk_hz > 100) ? 32'(clk_hz) - $urandom_range(100) : 32'(clk_hz);
            return FREQ_W'(wide);
        end else if (roll < 55) begin
            return FREQ_W'($urandom);
        end else if (clk_hz == 0) begin
            return FREQ_W'($urandom_range(10));
        end
        return FREQ_W'($urandom_range(32'(clk_hz), 1));
    endfunction

    function automatic logic [1:0] pick_command();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 25) begin
            return CMD_INIT;
        end else if (roll < 65) begin
            return CMD_SET;
        end else if (roll < 90) begin
            return CMD_FAULT;
        end
        return CMD_UNUSED;
    endfunction

    initial begin
        logic [FREQ_W-1:0] phase_clk;
        logic [FREQ_W-1:0] phase_fault;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CLOCK_HZ;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        clk_hz = CLOCK_HZ_RESET;
        fault_hz = FAULT_FREQ_RESET;
        last_freq = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Before the first init: fault and equal requests do nothing, set applies.
        send_request(CMD_FAULT, FREQ_MAX);
        send_request(CMD_SET, '0);
        send_request(CMD_UNUSED, '0);
        send_request(CMD_SET, 1000);
        send_request(CMD_FAULT, '0);
        send_request(CMD_INIT, '0);
        send_request(CMD_INIT, 24000001);
        send_request(CMD_INIT, FREQ_MAX);
        send_request(CMD_INIT, 24000000);
        send_request(CMD_INIT, 1);
        send_request(CMD_SET, 1);
        send_request(CMD_SET, 5700);
        send_request(CMD_FAULT, '0);
        send_request(CMD_SET, 366);
        send_request(CMD_FAULT, 12345);
        send_request(CMD_INIT, 5700);
        send_request(CMD_SET, '0);
        send_request(CMD_SET, 12000001);
        send_request(CMD_UNUSED, 27'h5555555);
        send_request(CMD_SET, 27'h2AAAAAA);
        send_request(CMD_INIT, 23999999);
        send_request(CMD_SET, 367);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin phase_clk = CLOCK_HZ_RESET; phase_fault = FAULT_FREQ_RESET; end
                1: begin phase_clk = 100000000; phase_fault = 1; end
                2: begin phase_clk = 1; phase_fault = FREQ_MAX; end
                3: begin phase_clk = FREQ_MAX; phase_fault = 100000000; end
                4: begin phase_clk = '0; phase_fault = 5700; end
                5: begin
                    phase_clk = FREQ_W'($urandom_range(200000, 1000));
                    phase_fault = FREQ_W'($urandom_range(5000, 1));
                end
                6: begin phase_clk = 24000000; phase_fault = '0; end
                default: begin
                    phase_clk = FREQ_W'($urandom);
                    phase_fault = FREQ_W'($urandom_range(100000, 1));
                end
            endcase
            write_register(CFG_CLOCK_HZ, phase_clk);
            write_register(CFG_FAULT_FREQ, phase_fault);
            case (phase % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 73; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 73; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            // Start each phase with an init, valid unless the clock register is zero, so set and fault reach real work.
            send_request(CMD_INIT, (clk_hz == 0) ? FREQ_W'(1) : FREQ_W'(clk_hz / 1000 + 1));
            for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
                send_request(pick_command(), pick_frequency());
            end
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> pwm_timing_calculator.f
hdl/pwm_tc_pkg.sv
hdl/pwm_tc_div.sv
hdl/pwm_timing_calculator.sv
sim/pwm_tc_monitor.sv
sim/tb_top.sv
